// ----- design/ist_pkg.sv -----
package ist_pkg;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_ist_state;

    typedef struct packed {
        logic               was_present;
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } t_ist_result;

endpackage

// ----- design/integer_set_table.sv -----
// Channel | Valid   | Ready   | Payload
// input   | i_valid | o_ready | i_func, i_value
// result  | o_valid | i_ready | o_was_present, o_count, o_dropped
//
// One item at a time. With N values held and a match at position p (from 0):
// accept, scan entries 0..p on a hit or all N on a miss, on remove shift the
// N-p-1 entries after p down one place, then register the result for output.
// The single read/write port pair of the value memory sets the scan and shift pace.
// Synchronous active-low reset empties the set; no clearing pass is needed.
// A held result does not block the next item; a new result then waits for i_ready.
module integer_set_table #(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ist_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [ist_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_was_present,
    output logic [ist_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_dropped
);

    import ist_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic               res_valid;
    logic               res_ack;
    t_ist_result        res;
    logic               r_out_valid;
    t_ist_result        r_out;

    ist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ist_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_ack   (res_ack),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    assign res_ack = res_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_was_present = r_out.was_present;
    assign o_count       = r_out.count;
    assign o_dropped     = r_out.dropped;

endmodule

// ----- design/ist_ram.sv -----
module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ist_seq.sv -----
module ist_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [ist_pkg::FUNC_W-1:0]           i_func,
    input  logic signed [ist_pkg::VALUE_W-1:0]   i_value,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ack,
    output ist_pkg::t_ist_result                 o_res,
    output logic                                 o_ram_we,
    output logic [$clog2(CAPACITY)-1:0]          o_ram_waddr,
    output logic [ist_pkg::VALUE_W-1:0]          o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [$clog2(CAPACITY)-1:0]          o_ram_raddr,
    input  logic [ist_pkg::VALUE_W-1:0]          i_ram_rdata
);

    import ist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    t_ist_state         r_state, n_state;
    logic [FUNC_W-1:0]  r_func;
    logic [VALUE_W-1:0] r_value;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_chk, n_chk;
    logic               r_present, n_present;
    logic               r_dropped, n_dropped;
    logic               hit;

    assign hit = r_pend && (i_ram_rdata == r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_func  <= i_func;
            r_value <= $unsigned(i_value);
        end
        r_ptr     <= n_ptr;
        r_chk     <= n_chk;
        r_present <= n_present;
        r_dropped <= n_dropped;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_chk       = r_chk;
        n_present   = r_present;
        n_dropped   = r_dropped;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = r_value;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_ptr[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_ptr     = '0;
                    n_pend    = 1'b0;
                    n_present = 1'b0;
                    n_dropped = 1'b0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit || r_ptr == r_count) begin
                    n_present = hit;
                    n_pend    = 1'b0;
                    n_state   = ST_DONE;
                    if (r_func == FN_ADD && !hit) begin
                        if (r_count < CAP) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_count[AW-1:0];
                            n_count     = r_count + CW'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end else if (r_func == FN_REMOVE && hit) begin
                        n_ptr   = CW'(r_chk) + CW'(1);
                        n_state = ST_SHIFT;
                    end
                end else begin
                    o_ram_re = 1'b1;
                    n_pend   = 1'b1;
                    n_chk    = r_ptr[AW-1:0];
                    n_ptr    = r_ptr + CW'(1);
                end
            end
            ST_SHIFT: begin
                // read runs one entry ahead of the write that closes the gap
                if (r_pend) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_chk - AW'(1);
                    o_ram_wdata = i_ram_rdata;
                end
                if (r_ptr < r_count) begin
                    o_ram_re = 1'b1;
                    n_pend   = 1'b1;
                    n_chk    = r_ptr[AW-1:0];
                    n_ptr    = r_ptr + CW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.was_present = r_present;
    assign o_res.count       = COUNT_W'(r_count);
    assign o_res.dropped     = r_dropped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("entry count above capacity");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == ST_SCAN || r_state == ST_SHIFT))
        else $error("memory write outside scan or shift");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && o_ram_re) |-> (o_ram_waddr < o_ram_raddr))
        else $error("shift write overtook read");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_dropped) |-> (r_count == CAP && !r_present))
        else $error("drop flagged with room left");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |=> $stable(r_count))
        else $error("count changed while not working");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import ist_pkg::*;

    localparam int  CAPACITY  = 64;
    localparam int  LATENCY   = 2 * CAPACITY + 8;
    localparam int  N_RANDOM  = 1800;
    localparam int  HOLD_AT   = 400;
    localparam int  HOLD_LEN  = 600;
    localparam int  MAX_CYCLE = 1200000;
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} t_mix;

    class t_set_scoreboard;
        logic signed [VALUE_W-1:0] members[$];
        t_ist_result               pending_answers[$];
        int                        n_fail;
        int                        n_results;

        function void apply_request(input logic [FUNC_W-1:0] func,
                                    input logic signed [VALUE_W-1:0] value);
            int          pos;
            t_ist_result ans;
            pos = -1;
            for (int i = 0; i < members.size() && pos < 0; i++)
                if (members[i] == value)
                    pos = i;
            ans.was_present = (pos >= 0);
            ans.dropped     = 1'b0;
            case (func)
                FN_ADD: begin
                    if (pos < 0) begin
                        if (members.size() < CAPACITY)
                            members.push_back(value);
                        else
                            ans.dropped = 1'b1;
                    end
                end
                FN_REMOVE: begin
                    if (pos >= 0)
                        members.delete(pos);
                end
                default: ;
            endcase
            ans.count = COUNT_W'(members.size());
            pending_answers.push_back(ans);
        endfunction

        function void check_result(input logic was_present,
                                   input logic [COUNT_W-1:0] count,
                                   input logic dropped);
            t_ist_result want;
            n_results++;
            if (pending_answers.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("%0t: result %0d with no transfer pending: p=%0b c=%0d d=%0b",
                             $time, n_results, was_present, count, dropped);
                return;
            end
            want = pending_answers.pop_front();
            if (want.was_present !== was_present || want.count !== count
                    || want.dropped !== dropped) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("%0t: result %0d: expected p=%0b c=%0d d=%0b, got p=%0b c=%0d d=%0b",
                             $time, n_results, want.was_present, want.count, want.dropped,
                             was_present, count, dropped);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [FUNC_W-1:0]         i_func = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_was_present;
    logic [COUNT_W-1:0]        o_count;
    logic                      o_dropped;

    t_set_scoreboard book = new();
    bit            steady = 1'b0;
    int            cycles = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    integer_set_table #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_func(i_func),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_was_present(o_was_present),
        .o_count(o_count),
        .o_dropped(o_dropped)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLE) begin
            $display("integer_set_table regression: fail");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (!hold_done && book.n_results >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            book.check_result(o_was_present, o_count, o_dropped);
    end

    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic signed [VALUE_W-1:0] value);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            i_func  <= FUNC_W'($urandom);
            i_value <= $urandom;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        book.apply_request(func, value);
    endtask

    // held: a current member; otherwise mostly fresh, some extremes and near misses
    function automatic logic signed [VALUE_W-1:0] pick_value(input bit held);
        int                        n;
        logic signed [VALUE_W-1:0] v;
        n = book.members.size();
        if (held && n > 0)
            return book.members[$urandom_range(0, n - 1)];
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = -32'sd1;
                    3: v = 32'sd0;
                    default: v = 32'sd1;
                endcase
            end
            1: begin
                if (n > 0)
                    v = book.members[$urandom_range(0, n - 1)]
                        ^ (32'sd1 << $urandom_range(0, 31));
                else
                    v = $urandom;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        t_mix phase;
        int   phase_left;
        int   roll;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(FN_LOOKUP, 32'sd0);
        send_request(FN_REMOVE, 32'sd0);
        send_request(FN_SPARE,  32'sd0);
        send_request(FN_ADD,    32'sd0);
        send_request(FN_ADD,    32'sh8000_0000);
        send_request(FN_ADD,    32'sh7FFF_FFFF);
        send_request(FN_ADD,    -32'sd1);
        send_request(FN_ADD,    32'sd0);
        send_request(FN_ADD,    32'sh5555_AAAA);
        send_request(FN_LOOKUP, -32'sd1);
        send_request(FN_LOOKUP, 32'shFFFF_FFFE);
        send_request(FN_SPARE,  32'sh7FFF_FFFF);
        send_request(FN_SPARE,  32'sh1234_5678);
        send_request(FN_REMOVE, 32'sh8000_0000);
        send_request(FN_LOOKUP, 32'sh8000_0000);
        send_request(FN_REMOVE, 32'sh5555_AAAA);
        send_request(FN_REMOVE, 32'sd0);
        send_request(FN_REMOVE, 32'sh1234_5678);
        send_request(FN_LOOKUP, 32'sh7FFF_FFFF);
        send_request(FN_ADD,    32'sh8000_0000);
        send_request(FN_REMOVE, -32'sd1);
        send_request(FN_REMOVE, 32'sh7FFF_FFFF);
        send_request(FN_REMOVE, 32'sh8000_0000);

        phase      = PH_FILL;
        phase_left = 180;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (phase_left == 0) begin
                phase      = t_mix'($urandom_range(0, 2));
                phase_left = $urandom_range(60, 180);
            end
            phase_left--;
            steady = (k >= 700 && k < 1000);
            roll   = $urandom_range(0, 99);
            case (phase)
                PH_FILL: begin
                    if (roll < 75)      send_request(FN_ADD, pick_value(1'b0));
                    else if (roll < 85) send_request(FN_ADD, pick_value(1'b1));
                    else if (roll < 93) send_request(FN_LOOKUP, pick_value(roll[0]));
                    else if (roll < 97) send_request(FN_REMOVE, pick_value(1'b1));
                    else                send_request(FN_SPARE, pick_value(roll[0]));
                end
                PH_DRAIN: begin
                    if (roll < 55)      send_request(FN_REMOVE, pick_value(1'b1));
                    else if (roll < 65) send_request(FN_REMOVE, pick_value(1'b0));
                    else if (roll < 80) send_request(FN_ADD, pick_value(1'b0));
                    else if (roll < 95) send_request(FN_LOOKUP, pick_value(roll[0]));
                    else                send_request(FN_SPARE, pick_value(roll[0]));
                end
                default: begin
                    if (roll < 30)      send_request(FN_ADD, pick_value(1'b0));
                    else if (roll < 45) send_request(FN_ADD, pick_value(1'b1));
                    else if (roll < 65) send_request(FN_REMOVE, pick_value(1'b1));
                    else if (roll < 72) send_request(FN_REMOVE, pick_value(1'b0));
                    else if (roll < 92) send_request(FN_LOOKUP, pick_value(roll[0]));
                    else                send_request(FN_SPARE, pick_value(roll[0]));
                end
            endcase
        end
        steady = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;

        while (book.pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);

        if (book.pending_answers.size() != 0) begin
            book.n_fail++;
            $display("%0d expected results never arrived", book.pending_answers.size());
        end
        if (book.n_fail == 0)
            $display("integer_set_table regression: pass");
        else
            $display("integer_set_table regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/ist_pkg.sv
design/ist_ram.sv
design/ist_seq.sv
design/integer_set_table.sv
verif/tb_top.sv
